@@ rtl/hrsl_pkg.sv @@
package hrsl_pkg;

  localparam logic [7:0] COLON_CHAR = 8'h3A;

  // Record types
  localparam logic [7:0] RT_DATA      = 8'h00;
  localparam logic [7:0] RT_EOF       = 8'h01;
  localparam logic [7:0] RT_EXT_SEG   = 8'h02;
  localparam logic [7:0] RT_START_SEG = 8'h03;
  localparam logic [7:0] RT_EXT_LIN   = 8'h04;
  localparam logic [7:0] RT_START_LIN = 8'h05;

  localparam logic [31:0] SECTION_MAX_RESET = 32'd4096;

  // Token queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    ST_DATA       = 3'd0,
    ST_START_WARN = 3'd1,
    ST_FINISHED   = 3'd2,
    ST_BAD_SUM    = 3'd3,
    ST_BAD_TYPE   = 3'd4,
    ST_EARLY_END  = 3'd5,
    ST_BAD_DIGIT  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    TK_DATA   = 2'd0,  // data byte, value = offset + index
    TK_SEG    = 2'd1,  // segment base update, value = new base
    TK_LIN    = 2'd2,  // linear base update, value = new base
    TK_REPORT = 2'd3   // status report
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    status_t     status;
    logic [7:0]  data;
    logic [16:0] value;
  } tok_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

@@ rtl/hex_record_stream_loader_core.sv @@
// Hex-record stream loader.
// Input channel (in_valid/in_ready, kind, ch): one transaction per text
// character; kind=1 marks end of input. Characters outside a record are
// skipped until ':'.
// Output channel (out_valid/out_ready, status, data_byte, byte_address,
// new_section): one transaction per decoded data byte, start-address warning,
// end record or error. Data bytes are sent before their record's checksum is
// checked, so after any error status the consumer drops what it got.
// Config: cfg_wr_en/cfg_wr_data write section_max_size (reset 4096); write
// only while the block is idle.
// Throughput: one character per cycle while the token queue has room. A result
// passes through front decode into a 4-entry token queue at the accepting
// edge, then through the back end's address/section logic into the output
// register once that register is empty or being taken.
// Stalls: out_ready low holds the output register; the queue absorbs up to
// four tokens, then in_ready drops until the back end drains.
// Reset (rst, synchronous): parser idle, bases and section tracking cleared,
// queue and output empty. After finished or any error the block produces no
// more results until reset, though it keeps accepting input.
module hex_record_stream_loader_core
  import hrsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  data_byte,
  output logic [31:0] byte_address,
  output logic        new_section
);

  logic    take;
  logic    q_push;
  tok_t    q_wdata;
  logic    q_full;
  logic    q_avail;
  logic    q_pop;
  tok_t    q_rdata;
  status_t out_status;

  // Accept whenever the token queue has room, produced token or not.
  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  hrsl_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .kind (kind),
    .ch   (ch),
    .push (q_push),
    .tok  (q_wdata)
  );

  hrsl_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .avail (q_avail),
    .pop   (q_pop),
    .rdata (q_rdata)
  );

  // Back end: address build, section tracking, base updates, halt.
  hrsl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tok_avail   (q_avail),
    .tok         (q_rdata),
    .tok_pop     (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .out_byte    (data_byte),
    .out_addr    (byte_address),
    .out_new     (new_section)
  );

  assign status = out_status;

endmodule

@@ rtl/hrsl_front.sv @@
module hrsl_front
  import hrsl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic       kind,
  input  logic [7:0] ch,
  output logic       push,
  output tok_t       tok
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_COUNT, PH_OFF_HI, PH_OFF_LO, PH_TYPE, PH_DATA, PH_CKSUM
  } phase_t;

  phase_t      phase;
  logic        nib_pend;
  logic [3:0]  nib_hi;
  logic [7:0]  rec_count;
  logic [15:0] rec_offset;
  logic [7:0]  rec_type;
  logic [7:0]  sum;
  logic [7:0]  seen;
  logic [15:0] pend_base;

  logic [4:0]  dig;
  logic [7:0]  b;
  logic [7:0]  sum_new;
  logic [7:0]  seen_inc;

  assign dig      = hex_digit(ch);
  assign b        = {nib_hi, dig[3:0]};
  assign sum_new  = sum + b;
  assign seen_inc = seen + 8'd1;

  // Token generation
  always_comb begin
    push = 1'b0;
    tok.kind   = TK_REPORT;
    tok.status = ST_DATA;
    tok.data   = b;
    tok.value  = {1'b0, rec_offset} + {9'd0, seen};
    if (take) begin
      if (kind) begin
        push = 1'b1;
        tok.status = ST_EARLY_END;
      end else if (phase != PH_IDLE) begin
        if (!dig[4]) begin
          push = 1'b1;
          tok.status = ST_BAD_DIGIT;
        end else if (nib_pend) begin
          if (phase == PH_DATA && rec_type == RT_DATA) begin
            push = 1'b1;
            tok.kind = TK_DATA;
          end else if (phase == PH_CKSUM) begin
            tok.value = {1'b0, pend_base};
            if (sum_new != 8'd0) begin
              push = 1'b1;
              tok.status = ST_BAD_SUM;
            end else begin
              unique case (rec_type)
                RT_DATA:    push = 1'b0;
                RT_EOF: begin
                  push = 1'b1;
                  tok.status = ST_FINISHED;
                end
                RT_EXT_SEG: begin
                  push = 1'b1;
                  tok.kind = TK_SEG;
                end
                RT_EXT_LIN: begin
                  push = 1'b1;
                  tok.kind = TK_LIN;
                end
                RT_START_SEG, RT_START_LIN: begin
                  push = 1'b1;
                  tok.status = ST_START_WARN;
                end
                default: begin
                  push = 1'b1;
                  tok.status = ST_BAD_TYPE;
                end
              endcase
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      nib_pend  <= 1'b0;
      nib_hi    <= 4'd0;
      rec_count <= 8'd0;
      rec_offset <= 16'd0;
      rec_type  <= 8'd0;
      sum       <= 8'd0;
      seen      <= 8'd0;
      pend_base <= 16'd0;
    end else if (take && !kind) begin
      if (phase == PH_IDLE) begin
        if (ch == COLON_CHAR) begin
          phase      <= PH_COUNT;
          sum        <= 8'd0;
          nib_pend   <= 1'b0;
          nib_hi     <= 4'd0;
          seen       <= 8'd0;
          rec_offset <= 16'd0;
          pend_base  <= 16'd0;
        end
      end else if (dig[4]) begin
        if (!nib_pend) begin
          nib_hi   <= dig[3:0];
          nib_pend <= 1'b1;
        end else begin
          nib_pend <= 1'b0;
          sum      <= sum_new;
          unique case (phase)
            PH_COUNT: begin
              rec_count <= b;
              phase     <= PH_OFF_HI;
            end
            PH_OFF_HI: begin
              rec_offset <= {b, 8'd0};
              phase      <= PH_OFF_LO;
            end
            PH_OFF_LO: begin
              rec_offset <= {rec_offset[15:8], b};
              phase      <= PH_TYPE;
            end
            PH_TYPE: begin
              rec_type  <= b;
              seen      <= 8'd0;
              pend_base <= 16'd0;
              phase     <= (rec_count != 8'd0) ? PH_DATA : PH_CKSUM;
            end
            PH_DATA: begin
              if (rec_type != RT_DATA) begin
                if (seen == 8'd0) begin
                  pend_base <= {b, 8'd0};
                end else if (seen == 8'd1) begin
                  pend_base <= {pend_base[15:8], b};
                end
              end
              seen <= seen_inc;
              if (seen_inc == rec_count) begin
                phase <= PH_CKSUM;
              end
            end
            default: phase <= PH_IDLE;  // checksum byte ends the record
          endcase
        end
      end
    end
  end

endmodule

@@ rtl/hrsl_fifo.sv @@
module hrsl_fifo
  import hrsl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tok_t wdata,
  output logic full,
  output logic avail,
  input  logic pop,
  output tok_t rdata
);

  tok_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full  = (count == QDEPTH[QAW:0]);
  assign avail = (count != '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
    end
  end

endmodule

@@ rtl/hrsl_back.sv @@
module hrsl_back
  import hrsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        tok_avail,
  input  tok_t        tok,
  output logic        tok_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output status_t     out_status,
  output logic [7:0]  out_byte,
  output logic [31:0] out_addr,
  output logic        out_new
);

  logic [31:0] section_max;
  logic [15:0] linear_base;
  logic [15:0] segment_base;
  logic [31:0] base_sum;      // (linear << 16) + segment * 16
  logic [31:0] next_addr;
  logic [31:0] fill;
  logic        sec_open;
  logic        halted;

  logic [31:0] addr;
  logic [31:0] addr_inc;
  logic        ns;
  logic        emit;

  assign tok_pop  = tok_avail && (!out_valid || out_ready);
  assign addr     = base_sum + {15'd0, tok.value};
  assign addr_inc = base_sum + {15'd0, tok.value} + 32'd1;
  assign ns       = !sec_open || (addr != next_addr) || (fill >= section_max);
  // token that loads the output register
  assign emit     = tok_pop && !halted && (tok.kind == TK_DATA || tok.kind == TK_REPORT);

  always_ff @(posedge clk) begin
    if (rst) begin
      section_max  <= SECTION_MAX_RESET;
      linear_base  <= 16'd0;
      segment_base <= 16'd0;
      base_sum     <= 32'd0;
      next_addr    <= 32'd0;
      fill         <= 32'd0;
      sec_open     <= 1'b0;
      halted       <= 1'b0;
      out_valid    <= 1'b0;
      out_status   <= ST_DATA;
      out_byte     <= 8'd0;
      out_addr     <= 32'd0;
      out_new      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        section_max <= cfg_wr_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (tok_pop && !halted) begin
        unique case (tok.kind)
          TK_DATA: begin
            fill       <= ns ? 32'd1 : fill + 32'd1;
            sec_open   <= 1'b1;
            next_addr  <= addr_inc;
            out_status <= ST_DATA;
            out_byte   <= tok.data;
            out_addr   <= addr;
            out_new    <= ns;
          end
          TK_SEG: begin
            segment_base <= tok.value[15:0];
            base_sum     <= {linear_base, 16'd0} + {12'd0, tok.value[15:0], 4'd0};
          end
          TK_LIN: begin
            linear_base <= tok.value[15:0];
            base_sum    <= {tok.value[15:0], 16'd0} + {12'd0, segment_base, 4'd0};
          end
          TK_REPORT: begin
            out_status <= tok.status;
            out_byte   <= 8'd0;
            out_addr   <= 32'd0;
            out_new    <= 1'b0;
            halted     <= (tok.status != ST_START_WARN);
          end
        endcase
      end
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

// Testbench for the hex-record stream loader.
// A short table of characters checks the first records after reset; random
// record streams follow under several section limits and idle patterns. Every
// accepted character goes through a local decoder that tracks the same parser
// state, and its output is queued and compared with each output transaction.
module tb;
  import hrsl_pkg::*;

  localparam int CYCLE_LIMIT = 300_000;
  localparam int QUIET_CYCLES = 8;   // settle time after the last owed output; leave margin
  localparam int HOLD_CYCLES = 300;  // long output stall, fills the token queue

  localparam logic [7:0] CH_ZERO    = "0";
  localparam logic [7:0] CH_NINE    = "9";
  localparam logic [7:0] CH_UPPER_A = "A";
  localparam logic [7:0] CH_UPPER_F = "F";
  localparam logic [7:0] CH_LOWER_A = "a";
  localparam logic [7:0] CH_LOWER_F = "f";

  typedef enum logic [2:0] {
    P_IDLE, P_COUNT, P_OFF_HI, P_OFF_LO, P_TYPE, P_DATA, P_SUM
  } parse_e;

  // how the stream is closed at the end of the run
  typedef enum int {
    END_RECORD, END_BAD_SUM, END_BAD_TYPE, END_EARLY, END_BAD_DIGIT
  } ending_e;

  typedef struct packed {
    status_t     status;
    logic [7:0]  data_byte;
    logic [31:0] byte_address;
    logic        new_section;
  } load_result_t;

  // one directed character; when typed is set, has/res replace the decoder's view
  typedef struct packed {
    logic         kind;
    logic [7:0]   ch;
    bit           typed;
    bit           has;
    load_result_t res;
  } stim_row_t;

  localparam load_result_t NOTHING = '0;

  // Directed stream: char extremes skipped while idle, a two-byte data record in
  // lower case right after reset (fresh section at address 0, then a contiguous
  // byte), and an empty start-address record that warns without halting.
  localparam stim_row_t DIRECTED_ROWS [0:27] = '{
    '{1'b0, 8'h00, 1'b1, 1'b0, NOTHING}, '{1'b0, 8'hFF, 1'b1, 1'b0, NOTHING},
    '{1'b0, ":", 1'b0, 1'b0, NOTHING},
    '{1'b0, "0", 1'b0, 1'b0, NOTHING}, '{1'b0, "2", 1'b0, 1'b0, NOTHING},
    '{1'b0, "0", 1'b0, 1'b0, NOTHING}, '{1'b0, "0", 1'b0, 1'b0, NOTHING},
    '{1'b0, "0", 1'b0, 1'b0, NOTHING}, '{1'b0, "0", 1'b0, 1'b0, NOTHING},
    '{1'b0, "0", 1'b0, 1'b0, NOTHING}, '{1'b0, "0", 1'b0, 1'b0, NOTHING},
    '{1'b0, "f", 1'b0, 1'b0, NOTHING},
    '{1'b0, "f", 1'b1, 1'b1, '{ST_DATA, 8'hFF, 32'h0000_0000, 1'b1}},
    '{1'b0, "0", 1'b0, 1'b0, NOTHING},
    '{1'b0, "0", 1'b1, 1'b1, '{ST_DATA, 8'h00, 32'h0000_0001, 1'b0}},
    '{1'b0, "f", 1'b0, 1'b0, NOTHING}, '{1'b0, "f", 1'b0, 1'b0, NOTHING},
    '{1'b0, ":", 1'b0, 1'b0, NOTHING},
    '{1'b0, "0", 1'b0, 1'b0, NOTHING}, '{1'b0, "0", 1'b0, 1'b0, NOTHING},
    '{1'b0, "0", 1'b0, 1'b0, NOTHING}, '{1'b0, "0", 1'b0, 1'b0, NOTHING},
    '{1'b0, "0", 1'b0, 1'b0, NOTHING}, '{1'b0, "0", 1'b0, 1'b0, NOTHING},
    '{1'b0, "0", 1'b0, 1'b0, NOTHING}, '{1'b0, "3", 1'b0, 1'b0, NOTHING},
    '{1'b0, "F", 1'b0, 1'b0, NOTHING},
    '{1'b0, "D", 1'b1, 1'b1, '{ST_START_WARN, 8'h00, 32'h0000_0000, 1'b0}}
  };

  // DUT ports
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = 1'b0;
  logic [7:0]  ch = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [7:0]  data_byte;
  logic [31:0] byte_address;
  logic        new_section;

  // decoder copy of the parser state
  parse_e      parse_st = P_IDLE;
  logic [3:0]  hi_nib = '0;
  bit          nib_pending = 1'b0;
  logic [7:0]  rec_count = '0;
  logic [15:0] rec_off = '0;
  logic [7:0]  rec_type = '0;
  logic [7:0]  run_sum = '0;
  logic [7:0]  seen = '0;
  logic [15:0] base_pending = '0;
  logic [15:0] lin_base = '0;
  logic [15:0] seg_base = '0;
  logic [31:0] next_addr = '0;
  logic [31:0] fill = '0;
  bit          sec_open = 1'b0;
  bit          halted_st = 1'b0;
  logic [31:0] section_limit = SECTION_MAX_RESET;

  load_result_t outputs_due [$];

  // directed-row override
  bit           typed_row = 1'b0;
  bit           typed_has = 1'b0;
  load_result_t typed_res = '0;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  int          hold_left = 0;
  bit          big_done = 1'b0;   // one full 255-byte record per run at most
  logic [15:0] run_offset = '0;   // next contiguous offset for data records

  int mismatches = 0;
  int cycle_count = 0;
  int chars_accepted = 0;
  int record_chars = 0;
  int data_seen = 0;
  int sections_seen = 0;
  int warns_seen = 0;
  int stall_cycles = 0;

  hex_record_stream_loader_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .ch           (ch),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .data_byte    (data_byte),
    .byte_address (byte_address),
    .new_section  (new_section)
  );

  always #5 clk = ~clk;

  // -1 for anything that is not a hex digit
  function automatic int digit_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c) - int'(CH_ZERO);
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c) - int'(CH_UPPER_A) + 10;
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c) - int'(CH_LOWER_A) + 10;
    return -1;
  endfunction

  // letters come out in either case
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CH_ZERO + {4'h0, n};
    return ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + {4'h0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == COLON_CHAR);
    return c;
  endfunction

  // Advances the local parser by one character; returns 1 when the block owes
  // an output transaction for it.
  function automatic bit decode_char(input logic k, input logic [7:0] c,
                                     output load_result_t r);
    int          d;
    logic [7:0]  b;
    logic [31:0] a;
    bit          ns;
    r = '0;
    if (halted_st) return 1'b0;
    if (k) begin
      r.status = ST_EARLY_END;
      halted_st = 1'b1;
      return 1'b1;
    end
    if (parse_st == P_IDLE) begin
      if (c == COLON_CHAR) begin
        parse_st = P_COUNT;
        run_sum = '0;
        nib_pending = 1'b0;
        hi_nib = '0;
        seen = '0;
        rec_off = '0;
        base_pending = '0;
      end
      return 1'b0;
    end
    d = digit_value(c);
    if (d < 0) begin
      r.status = ST_BAD_DIGIT;
      halted_st = 1'b1;
      return 1'b1;
    end
    if (!nib_pending) begin
      hi_nib = 4'(d);
      nib_pending = 1'b1;
      return 1'b0;
    end
    nib_pending = 1'b0;
    b = {hi_nib, 4'(d)};
    run_sum = run_sum + b;
    case (parse_st)
      P_COUNT: begin
        rec_count = b;
        parse_st = P_OFF_HI;
      end
      P_OFF_HI: begin
        rec_off = {b, 8'h00};
        parse_st = P_OFF_LO;
      end
      P_OFF_LO: begin
        rec_off[7:0] = b;
        parse_st = P_TYPE;
      end
      P_TYPE: begin
        rec_type = b;
        seen = '0;
        base_pending = '0;
        parse_st = (rec_count != 8'd0) ? P_DATA : P_SUM;
      end
      P_DATA: begin
        ns = 1'b0;
        if (rec_type == RT_DATA) begin
          a = {lin_base, rec_off} + {12'h000, seg_base, 4'h0} + {24'h0, seen};
          ns = !sec_open || a != next_addr || fill >= section_limit;
          if (ns) fill = '0;
          fill = fill + 32'd1;
          sec_open = 1'b1;
          next_addr = a + 32'd1;
          r = '{ST_DATA, b, a, ns};
        end else if (seen == 8'd0) begin
          base_pending = {b, 8'h00};
        end else if (seen == 8'd1) begin
          base_pending[7:0] = b;
        end
        seen = seen + 8'd1;
        if (seen == rec_count) parse_st = P_SUM;
        return rec_type == RT_DATA;
      end
      P_SUM: begin
        parse_st = P_IDLE;
        if (run_sum != 8'd0) begin
          r.status = ST_BAD_SUM;
          halted_st = 1'b1;
          return 1'b1;
        end
        case (rec_type)
          RT_DATA: return 1'b0;
          RT_EOF: begin
            r.status = ST_FINISHED;
            halted_st = 1'b1;
            return 1'b1;
          end
          RT_EXT_SEG: seg_base = base_pending;
          RT_EXT_LIN: lin_base = base_pending;
          RT_START_SEG, RT_START_LIN: begin
            r.status = ST_START_WARN;
            return 1'b1;
          end
          default: begin
            r.status = ST_BAD_TYPE;
            halted_st = 1'b1;
            return 1'b1;
          end
        endcase
      end
      default: parse_st = P_IDLE;
    endcase
    return 1'b0;
  endfunction

  // One input transaction. Valid stays up from the previous character unless
  // an idle gap is drawn; the decoder runs at the accepting edge.
  task automatic send_char(input logic k, input logic [7:0] c);
    load_result_t r;
    bit           got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    ch <= c;
    do @(posedge clk); while (!in_ready);
    got = decode_char(k, c, r);
    if (typed_row) begin
      got = typed_has;
      r = typed_res;
    end
    if (got) outputs_due.insert(outputs_due.size(), r);
    chars_accepted++;
  endtask

  // Full record text, optionally with noise in front and a corrupted checksum.
  task automatic send_record(input logic [7:0] rtype, input int count,
                             input logic [15:0] off, input bit bad_sum);
    logic [7:0] rec_bytes [$];
    logic [7:0] sum;
    logic [7:0] v;
    if ($urandom_range(2) == 0) repeat ($urandom_range(1, 2)) send_char(1'b0, noise_char());
    rec_bytes.insert(rec_bytes.size(), 8'(count));
    rec_bytes.insert(rec_bytes.size(), off[15:8]);
    rec_bytes.insert(rec_bytes.size(), off[7:0]);
    rec_bytes.insert(rec_bytes.size(), rtype);
    repeat (count) begin
      v = 8'($urandom);
      // base records lean toward all-ones so addresses wrap now and then
      if (rtype != RT_DATA && $urandom_range(3) == 0) v = 8'hFF;
      rec_bytes.insert(rec_bytes.size(), v);
    end
    sum = '0;
    foreach (rec_bytes[i]) sum = sum + rec_bytes[i];
    sum = -sum;
    if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
    rec_bytes.insert(rec_bytes.size(), sum);
    send_char(1'b0, COLON_CHAR);
    foreach (rec_bytes[i]) begin
      send_char(1'b0, hex_char(rec_bytes[i][7:4]));
      send_char(1'b0, hex_char(rec_bytes[i][3:0]));
    end
    record_chars += 1 + 2 * rec_bytes.size();
  endtask

  // Well-formed records with random content; data records mostly continue
  // where the last one ended, so sections grow until a gap or the limit.
  task automatic run_random_records(input int quota);
    int          start;
    int          pick;
    int          n;
    logic [15:0] off;
    start = record_chars;
    while (record_chars - start < quota) begin
      pick = $urandom_range(99);
      if (pick < 62) begin
        if (!big_done && $urandom_range(99) < 2) begin
          n = 255;
          big_done = 1'b1;
        end else if ($urandom_range(9) == 0) n = 0;   // empty data record
        else n = $urandom_range(1, 16);
        case ($urandom_range(19))
          0: off = 16'hFFF8;                      // can run across a 64K boundary
          1, 2, 3, 4: off = 16'($urandom);
          default: off = run_offset;
        endcase
        send_record(RT_DATA, n, off, 1'b0);
        run_offset = off + 16'(n);
      end else if (pick < 74) begin
        send_record(RT_EXT_LIN, $urandom_range(4), 16'($urandom), 1'b0);
      end else if (pick < 84) begin
        send_record(RT_EXT_SEG, $urandom_range(4), 16'($urandom), 1'b0);
      end else if (pick < 94) begin
        send_record(pick[0] ? RT_START_SEG : RT_START_LIN, $urandom_range(5),
                    16'($urandom), 1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) send_char(1'b0, noise_char());
      end
    end
  endtask

  // Drop valid, let every owed output arrive, then cover the pipeline latency
  // in case the last characters still sit in the token queue.
  task automatic wait_until_quiet();
    in_valid <= 1'b0;
    while (outputs_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic load_section_limit(input logic [31:0] v);
    wait_until_quiet();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    section_limit = v;
    cfg_wr_en <= 1'b0;
  endtask

  // Output side: random stalls, plus one long hold counted here so the
  // queue fills and in_ready drops while characters keep coming.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each output transaction with the oldest owed result.
  always @(posedge clk) begin
    load_result_t due;
    if (!rst && in_valid && !in_ready) stall_cycles++;
    if (!rst && out_valid && out_ready) begin
      if (outputs_due.size() == 0) begin
        $error("unexpected output transaction: status %0d", status);
        mismatches++;
      end else begin
        due = outputs_due.pop_front();
        if (status !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, status);
          mismatches++;
        end
        if (data_byte !== due.data_byte) begin
          $error("data_byte: expected %0h, got %0h", due.data_byte, data_byte);
          mismatches++;
        end
        if (byte_address !== due.byte_address) begin
          $error("byte_address: expected %0h, got %0h", due.byte_address, byte_address);
          mismatches++;
        end
        if (new_section !== due.new_section) begin
          $error("new_section: expected %0b, got %0b", due.new_section, new_section);
          mismatches++;
        end
      end
      if (status == ST_DATA) begin
        data_seen++;
        if (new_section) sections_seen++;
      end
      if (status == ST_START_WARN) warns_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("hex_record_stream_loader_core test failed");
      $finish;
    end
  end

  initial begin
    ending_e    ending;
    logic [7:0] c;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // phase 1: sender idles a quarter of the time, receiver most of it
    send_idle_pct = 25;
    recv_idle_pct <= 72;
    foreach (DIRECTED_ROWS[i]) begin
      typed_row = DIRECTED_ROWS[i].typed;
      typed_has = DIRECTED_ROWS[i].has;
      typed_res = DIRECTED_ROWS[i].res;
      send_char(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].ch);
    end
    typed_row = 1'b0;
    load_section_limit(32'd3);
    run_random_records(110);

    // phase 2: idle pattern swapped, section limit at its top
    load_section_limit(32'hFFFF_FFFF);
    send_idle_pct = 72;
    recv_idle_pct <= 25;
    run_random_records(110);

    // phase 3: no idling, one-byte sections, long output hold at the start
    load_section_limit(32'd1);
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_req <= 1'b1;
    run_random_records(110);

    // phase 4: limit of zero, every byte opens a section
    load_section_limit(32'd0);
    run_random_records(110);

    // close the stream one way; the block then stays silent until reset
    ending = ending_e'($urandom_range(4));
    case (ending)
      END_RECORD: send_record(RT_EOF, 0, 16'h0000, 1'b0);
      END_BAD_SUM: send_record($urandom_range(1) ? RT_DATA : RT_EXT_LIN,
                               $urandom_range(1, 4), run_offset, 1'b1);
      END_BAD_TYPE: send_record(8'($urandom_range(6, 255)), $urandom_range(3),
                                16'($urandom), 1'b0);
      default: begin
        // partial record, or none at all for an early end while idle
        if (ending == END_BAD_DIGIT || $urandom_range(1)) begin
          send_char(1'b0, COLON_CHAR);
          repeat ($urandom_range(7)) send_char(1'b0, hex_char(4'($urandom)));
        end
        if (ending == END_EARLY) begin
          send_char(1'b1, 8'($urandom));
        end else begin
          do c = 8'($urandom); while (digit_value(c) >= 0);
          if ($urandom_range(3) == 0) c = COLON_CHAR;
          send_char(1'b0, c);
        end
      end
    endcase
    send_char(1'b1, 8'hFF);
    send_char(1'b0, COLON_CHAR);
    repeat (6) send_char(1'b0, 8'($urandom));
    wait_until_quiet();

    $display("covered %0d characters (%0d in records), section limits 4096/3/max/1/0",
             chars_accepted, record_chars);
    $display("%0d data bytes, %0d section starts, %0d warnings, ending %s, %0d input stalls",
             data_seen, sections_seen, warns_seen, ending.name(), stall_cycles);
    if (mismatches == 0) begin
      $display("hex_record_stream_loader_core test passed");
    end else begin
      $display("hex_record_stream_loader_core test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/hrsl_pkg.sv
rtl/hrsl_front.sv
rtl/hrsl_fifo.sv
rtl/hrsl_back.sv
rtl/hex_record_stream_loader_core.sv
tb/tb.sv
